FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is switched off while reset is high.
`define WMF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds through reset.
`define WMF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/wmf_pkg.sv
// Types, constants and codes shared by the weighted median filter modules.
package wmf_pkg;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int STORED_ROWS   = 4;
  localparam int SLOT_W        = 2;
  localparam int WIN           = 5;
  localparam int HALF_WEIGHT   = 17;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 16;
  localparam int IMG_W_BITS    = 12;
  localparam int IMG_H_BITS    = 16;
  localparam int CFG_W         = 16;

  localparam logic ACT_PIXEL  = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Inner 3x3 of the window, bit index row*5+col; these taps count twice.
  localparam logic [WIN*WIN-1:0] INNER_MASK = 25'h0739C0;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } result_t;

  typedef logic [WIN-1:0][7:0] column_t;
  typedef logic [WIN-1:0][WIN-1:0][7:0] window_t;

  typedef struct packed {
    logic       shift;
    logic       emit;
    logic       interior;
    logic       frame_end;
    logic [7:0] pass_pix;
    column_t    col;
  } mid_t;

  typedef struct packed {
    logic       interior;
    logic       frame_end;
    logic [7:0] pass_pix;
  } med_tag_t;
endpackage

FILE: rtl/weighted_median_5x5_filter.sv
// Top level of the 5x5 weighted median filter for raster grayscale streams.
//
// Input queue: drive item with push; a transaction completes when push is high
// and full is low. A pixel item feeds the next raster pixel, a flush item
// drains the frame tail once every input pixel of the frame has arrived.
// Result queue: while empty is low the oldest result sits on result; a
// transaction completes when pop is high and empty is low.
// Output order lags input by 2*W+2 pixels. One item per cycle is taken while
// full is low: the front reads four line buffers per pixel, the back runs
// an eight-stage bit-search rank network, both fully pipelined.
// Configuration: a write of wr_data to register wr_index (0 width, 1 height)
// at any edge with wr_en high restarts the frame; write only while idle.
// Reset: positions clear, width and height return to 640 by 480. Line buffers
// are not cleared; no result reads an entry not written in the same frame.
// Stall: the result queue holds 16 entries; when it fills, the back end
// stops, the 4-entry queue between front and back fills, and full rises.
module weighted_median_5x5_filter #(
  parameter int MAX_WIDTH = wmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  wmf_pkg::item_t            item,
  output logic                      empty,
  input  logic                      pop,
  output wmf_pkg::result_t          result,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [wmf_pkg::CFG_W-1:0] wr_data
);
  import wmf_pkg::*;

  localparam int CNTW = $clog2(MID_DEPTH+1);

  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic                  mid_push, mid_pop;
  mid_t                  mid_in, mid_out;
  logic [CNTW-1:0]       mid_count;

  // Hold the frame size; a write takes effect at the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_BITS'(RESET_WIDTH);
      image_height <= IMG_H_BITS'(RESET_HEIGHT);
    end else if (wr_en) begin
      case (wr_index)
        REG_WIDTH:  image_width  <= wr_data[IMG_W_BITS-1:0];
        REG_HEIGHT: image_height <= wr_data[IMG_H_BITS-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  // Front: classify the item, advance positions, read the line buffers.
  wmf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (wr_en),
    .image_width  (image_width),
    .image_height (image_height),
    .push         (push),
    .item         (item),
    .full         (full),
    .mid_count    (mid_count),
    .mid_push     (mid_push),
    .mid_data     (mid_in)
  );

  // Decouple front and back so either side can stall alone.
  wmf_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .pop   (mid_pop),
    .dout  (mid_out),
    .count (mid_count)
  );

  // Back: shift the window, rank, and queue the results.
  wmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_count (mid_count),
    .mid_data  (mid_out),
    .mid_pop   (mid_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );
endmodule

FILE: rtl/wmf_fifo.sv
// Small first-in first-out queue built from registers.
module wmf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  assign dout = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end
endmodule

FILE: rtl/wmf_front.sv
// Front end: raster positions, line buffers and classification of each item.
module wmf_front #(
  parameter int MAX_WIDTH = wmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    restart,
  input  logic [wmf_pkg::IMG_W_BITS-1:0]          image_width,
  input  logic [wmf_pkg::IMG_H_BITS-1:0]          image_height,
  input  logic                                    push,
  input  wmf_pkg::item_t                          item,
  output logic                                    full,
  input  logic [$clog2(wmf_pkg::MID_DEPTH+1)-1:0] mid_count,
  output logic                                    mid_push,
  output wmf_pkg::mid_t                           mid_data
);
  import wmf_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH+1);
  localparam int WX   = WW + 1;
  localparam int PW   = $clog2(2*MAX_WIDTH+3);
  localparam int XW   = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
  localparam int CNTW = $clog2(MID_DEPTH+1);
  localparam int HX   = IMG_H_BITS + 1;

  logic [XW-1:0]         w_raw;
  logic [WW-1:0]         w;
  logic [IMG_H_BITS-1:0] h;
  logic [PW-1:0]         lag;

  logic [IMG_H_BITS-1:0] in_row;
  logic [CW-1:0]         in_col;
  logic [IMG_H_BITS-1:0] out_row;
  logic [CW-1:0]         out_col;
  logic [PW-1:0]         pending;

  logic accept, done, pixel_br, flush_emit, emit, interior;
  logic col_last, out_col_last, out_row_last, frame_end;

  logic              s1_valid;
  logic              s1_shift, s1_emit, s1_interior, s1_fe;
  logic [7:0]        s1_pix;
  logic [SLOT_W-1:0] s1_in_slot, s1_out_slot;
  logic [7:0]        rd_a [STORED_ROWS];
  logic [7:0]        rd_b [STORED_ROWS];

  assign w_raw = XW'(image_width);

  always_comb begin
    if (w_raw == '0) begin
      w = WW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(w_raw);
    end
  end

  assign h   = (image_height == '0) ? IMG_H_BITS'(1) : image_height;
  assign lag = PW'({w, 1'b0}) + PW'(2);

  assign full = (CNTW+1)'(mid_count) + (CNTW+1)'(s1_valid) >= (CNTW+1)'(MID_DEPTH);

  assign accept     = push && !full;
  assign done       = in_row >= h;
  assign pixel_br   = accept && (item.action == ACT_PIXEL) && !done;
  assign flush_emit = accept && done;
  assign emit       = flush_emit || (pixel_br && (pending >= lag));

  assign interior = (out_row >= IMG_H_BITS'(2)) && (HX'(out_row) + HX'(2) < HX'(h))
                 && (out_col >= CW'(2)) && (WX'(out_col) + WX'(2) < WX'(w));

  assign col_last     = WW'(in_col) + WW'(1) >= w;
  assign out_col_last = WW'(out_col) + WW'(1) >= w;
  assign out_row_last = HX'(out_row) + HX'(1) >= HX'(h);
  assign frame_end    = out_col_last && out_row_last;

  always_ff @(posedge clk) begin
    if (rst || restart || (emit && frame_end)) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      pending <= '0;
    end else begin
      if (pixel_br) begin
        if (col_last) begin
          in_col <= '0;
          in_row <= in_row + IMG_H_BITS'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (emit) begin
        if (out_col_last) begin
          out_col <= '0;
          out_row <= out_row + IMG_H_BITS'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
      if (flush_emit) begin
        pending <= pending - PW'(1);
      end else if (pixel_br && !emit) begin
        pending <= pending + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pixel_br || flush_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_shift    <= pixel_br;
      s1_emit     <= emit;
      s1_interior <= interior;
      s1_fe       <= frame_end;
      s1_pix      <= item.pixel_in;
      s1_in_slot  <= in_row[SLOT_W-1:0];
      s1_out_slot <= out_row[SLOT_W-1:0];
    end
  end

  // One line buffer per stored row; reads return the old data on a collision.
  for (genvar k = 0; k < STORED_ROWS; k++) begin : g_slot
    logic [7:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (accept) begin
        rd_a[k] <= mem[in_col];
        rd_b[k] <= mem[out_col];
      end
      if (pixel_br && (in_row[SLOT_W-1:0] == SLOT_W'(k))) begin
        mem[in_col] <= item.pixel_in;
      end
    end
  end

  always_comb begin
    mid_data.shift     = s1_shift;
    mid_data.emit      = s1_emit;
    mid_data.interior  = s1_interior;
    mid_data.frame_end = s1_fe;
    mid_data.pass_pix  = rd_b[s1_out_slot];
    for (int k = 0; k < STORED_ROWS; k++) begin
      mid_data.col[k] = rd_a[SLOT_W'(s1_in_slot + SLOT_W'(k))];
    end
    mid_data.col[WIN-1] = s1_pix;
  end

  assign mid_push = s1_valid;
endmodule

FILE: rtl/wmf_median.sv
// Weighted median: eight-stage bit search, one result bit per stage.
module wmf_median (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  wmf_pkg::window_t   in_win,
  input  wmf_pkg::med_tag_t  in_tag,
  output logic               out_valid,
  output logic [7:0]         out_pix,
  output logic               out_fe
);
  import wmf_pkg::*;

  localparam int STAGES = 8;

  logic     st_valid [STAGES+1];
  window_t  st_win   [STAGES];
  logic [7:0] st_res [STAGES+1];
  med_tag_t st_tag   [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_win[0] <= in_win;
    st_res[0] <= '0;
    st_tag[0] <= in_tag;
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int B = STAGES - 1 - s;
    logic [7:0]         trial;
    logic [WIN*WIN-1:0] hits;
    logic [5:0]         wsum;

    // Weight of taps at or above the trial value; keep the bit if it reaches half.
    always_comb begin
      trial = st_res[s] | (8'd1 << B);
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          hits[r*WIN+c] = st_win[s][r][c] >= trial;
        end
      end
      wsum = 6'($countones(hits)) + 6'($countones(hits & INNER_MASK));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else begin
        st_valid[s+1] <= st_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      st_res[s+1] <= (wsum >= 6'(HALF_WEIGHT)) ? trial : st_res[s];
      st_tag[s+1] <= st_tag[s];
    end

    if (s < STAGES - 1) begin : g_win
      always_ff @(posedge clk) begin
        st_win[s+1] <= st_win[s];
      end
    end
  end

  assign out_valid = st_valid[STAGES];
  assign out_pix   = st_tag[STAGES].interior ? st_res[STAGES] : st_tag[STAGES].pass_pix;
  assign out_fe    = st_tag[STAGES].frame_end;
endmodule

FILE: rtl/wmf_back.sv
// Back end: 5x5 window, median pipeline and result queue with credit control.
module wmf_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [$clog2(wmf_pkg::MID_DEPTH+1)-1:0] mid_count,
  input  wmf_pkg::mid_t                           mid_data,
  output logic                                    mid_pop,
  input  logic                                    pop,
  output logic                                    empty,
  output wmf_pkg::result_t                        result
);
  import wmf_pkg::*;

  localparam int IW = $clog2(OUT_DEPTH+1);

  window_t   win, win_next;
  logic [IW-1:0] inflight;
  logic [IW-1:0] out_count;
  logic      med_in_valid, res_pop;
  med_tag_t  tag;
  logic      med_valid, med_fe;
  logic [7:0] med_pix;
  result_t   med_res;

  // Take an entry that emits only when a result slot is free for it; others need no slot.
  assign mid_pop = (mid_count != '0) && (!mid_data.emit || (inflight < IW'(OUT_DEPTH)));
  assign med_in_valid = mid_pop && mid_data.emit;
  assign res_pop = pop && !empty;

  always_comb begin
    win_next = win;
    if (mid_pop && mid_data.shift) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN-1; c++) begin
          win_next[r][c] = win[r][c+1];
        end
        win_next[r][WIN-1] = mid_data.col[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({med_in_valid, res_pop})
        2'b10:   inflight <= inflight + IW'(1);
        2'b01:   inflight <= inflight - IW'(1);
        default: inflight <= inflight;
      endcase
    end
  end

  assign tag.interior  = mid_data.interior;
  assign tag.frame_end = mid_data.frame_end;
  assign tag.pass_pix  = mid_data.pass_pix;

  wmf_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (med_in_valid),
    .in_win    (win_next),
    .in_tag    (tag),
    .out_valid (med_valid),
    .out_pix   (med_pix),
    .out_fe    (med_fe)
  );

  assign med_res.pixel_out = med_pix;
  assign med_res.frame_end = med_fe;

  wmf_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (med_valid),
    .din   (med_res),
    .pop   (res_pop),
    .dout  (result),
    .count (out_count)
  );

  assign empty = (out_count == '0);
endmodule

FILE: rtl/wmf_checker.sv
// Port-level checker for the weighted median filter and its bind.
`include "assert_macros.svh"

module wmf_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input wmf_pkg::result_t result
);
  `WMF_ASSERT_NR(a_reset_empty, clk, $past(rst) |-> empty, "result queue not empty after reset")
  `WMF_ASSERT_NR(a_reset_not_full, clk, $past(rst) |-> !full, "input full after reset")
  `WMF_ASSERT_NR(a_no_early_result, clk, $past($past(rst)) |-> empty, "result too soon after reset")
  `WMF_ASSERT(a_hold, clk, rst, !empty && !pop |=> !empty && $stable(result), "stalled result moved")
endmodule

bind weighted_median_5x5_filter wmf_checker u_wmf_checker (.*);

FILE: bench/wmf_checker.sv
// Checker for the weighted median filter: predicts results and compares them.
module wmf_scoreboard
  import wmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  item_t            item,
  input  logic             empty,
  input  logic             pop,
  input  result_t          result,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output int               errors,
  output int               pending,
  output int               items_seen,
  output int               results_seen,
  output int               frames_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] line_mem [0:STORED_ROWS*MAX_WIDTH_DEF-1];
  logic [7:0] win [0:4][0:4];
  int unsigned in_r, in_c, out_r, out_c;
  logic [IMG_W_BITS-1:0] cfg_w;
  logic [IMG_H_BITS-1:0] cfg_h;
  result_t pixel_q[$];

  function automatic int unsigned eff_w();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return cfg_w;
  endfunction

  function automatic int unsigned slot(int unsigned r, int unsigned c);
    return (r % STORED_ROWS) * MAX_WIDTH_DEF + (c % MAX_WIDTH_DEF);
  endfunction

  function automatic logic [7:0] rank_median();
    logic [7:0] v [0:24];
    int         g [0:24];
    logic [7:0] x;
    int         wt, k, n, acc;
    n = 0;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++) begin
        x  = win[r][c];
        wt = (r >= 1 && r <= 3 && c >= 1 && c <= 3) ? 2 : 1;
        k  = n;
        while (k > 0 && v[k-1] < x) begin
          v[k] = v[k-1];
          g[k] = g[k-1];
          k--;
        end
        v[k] = x;
        g[k] = wt;
        n++;
      end
    acc = 0;
    for (int i = 0; i < 25; i++) begin
      acc += g[i];
      if (acc >= HALF_WEIGHT) return v[i];
    end
    return v[24];
  endfunction

  task automatic restart_frame();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++) win[r][c] = 8'd0;
  endtask

  function automatic logic [7:0] out_pixel(int unsigned w, int unsigned h);
    if (out_r >= 2 && out_r + 2 < h && out_c >= 2 && out_c + 2 < w)
      return rank_median();
    return line_mem[slot(out_r, out_c)];
  endfunction

  task automatic queue_pixel(logic [7:0] px, int unsigned w, int unsigned h);
    result_t r;
    r.pixel_out = px;
    r.frame_end = 1'b0;
    out_c++;
    if (out_c >= w) begin
      out_c = 0;
      out_r++;
      if (out_r >= h) begin
        restart_frame();
        r.frame_end = 1'b1;
      end
    end
    pixel_q.push_back(r);
  endtask

  task automatic predict(item_t it);
    int unsigned w, h, got, done;
    logic [7:0]  px;
    w = eff_w();
    h = (cfg_h == 0) ? 1 : cfg_h;
    if (it.action == ACT_FLUSH || in_r >= h) begin
      // Flush before the frame is complete drops out with nothing.
      if (in_r >= h) queue_pixel(out_pixel(w, h), w, h);
    end else begin
      for (int r = 0; r < 5; r++)
        for (int c = 0; c < 4; c++) win[r][c] = win[r][c+1];
      for (int k = 0; k < 4; k++) win[k][4] = line_mem[slot(in_r + k, in_c)];
      win[4][4] = it.pixel_in;
      got  = in_r * w + in_c + 1;
      done = out_r * w + out_c;
      if (got >= done + 2 * w + 3) px = out_pixel(w, h);
      line_mem[slot(in_r, in_c)] = it.pixel_in;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
      if (got >= done + 2 * w + 3) queue_pixel(px, w, h);
    end
  endtask

  task automatic report(string what, result_t exp_r, result_t act_r);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected pix %0d end %0b, got pix %0d end %0b",
               what, exp_r.pixel_out, exp_r.frame_end, act_r.pixel_out, act_r.frame_end);
  endtask

  initial begin
    errors = 0; items_seen = 0; results_seen = 0; frames_seen = 0;
    pending = 0;
    for (int i = 0; i < STORED_ROWS * MAX_WIDTH_DEF; i++) line_mem[i] = 8'd0;
    cfg_w = RESET_WIDTH;
    cfg_h = RESET_HEIGHT;
    restart_frame();
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      cfg_w = RESET_WIDTH;
      cfg_h = RESET_HEIGHT;
      restart_frame();
      pixel_q.delete();
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (result.frame_end) frames_seen++;
        if (pixel_q.size() == 0) begin
          exp_r = '0;
          report("unexpected", exp_r, result);
        end else begin
          exp_r = pixel_q.pop_front();
          if (exp_r.pixel_out !== result.pixel_out || exp_r.frame_end !== result.frame_end)
            report("value", exp_r, result);
        end
      end
      if (wr_en) begin
        if (wr_index == REG_WIDTH) cfg_w = wr_data[IMG_W_BITS-1:0];
        else cfg_h = wr_data[IMG_H_BITS-1:0];
        restart_frame();
      end
      if (push && !full) begin
        items_seen++;
        predict(item);
      end
    end
    pending = pixel_q.size();
  end
endmodule

FILE: bench/tb_top.sv
// Testbench top: drives frames into the weighted median filter and gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wmf_pkg::*;

  localparam int QUIET_LIMIT = 20000;  // cycles with no transaction before giving up
  localparam int SETTLE      = 64;     // pipeline settling margin before config writes and at run end

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  item_t            item = '0;
  logic             empty;
  logic             pop = 1'b0;
  result_t          result;
  logic             wr_en = 1'b0;
  logic             wr_index = REG_WIDTH;
  logic [CFG_W-1:0] wr_data = '0;

  int errors, pending, items_seen, results_seen, frames_seen;
  int gap_pct   = 0;   // chance the sender idles before a transaction
  int stall_pct = 0;   // chance the receiver holds off pop
  int quiet     = 0;
  int sent      = 0;
  int phase_no  = 0;

  weighted_median_5x5_filter dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .wr_en, .wr_index, .wr_data
  );

  wmf_scoreboard chk (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .wr_en, .wr_index, .wr_data,
    .errors, .pending, .items_seen, .results_seen, .frames_seen
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side: decide pop on every falling edge.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Rotate the idling pattern: none, sender gaps, receiver stalls, both.
  task automatic next_mode();
    case (phase_no % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 68; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 68; end
      default: begin gap_pct = 22; stall_pct = 22; end
    endcase
    phase_no++;
  endtask

  // Drive one transaction and hold it until the block takes it.
  task automatic send(logic act, logic [7:0] px);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push        <= 1'b1;
    item.action   <= act;
    item.pixel_in <= px;
    sent++;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Drop push, wait for every expected result, then let the pipe settle.
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both registers; this restarts the frame.
  task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    wr_en <= 1'b1; wr_index <= REG_WIDTH; wr_data <= w;
    @(negedge clk);
    wr_index <= REG_HEIGHT; wr_data <= h;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(120, 135));
      default: return 8'($urandom);
    endcase
  endfunction

  // Stream a full frame plus the flushes that drain its tail.
  task automatic run_frame(int w, int h, int noise_pct);
    int ew, eh;
    ew = (w == 0) ? 1 : (w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w);
    eh = (h == 0) ? 1 : h;
    for (int i = 0; i < ew * eh; i++) begin
      // Early flushes produce nothing; scatter a few as noise.
      if ($urandom_range(99) < noise_pct) send(ACT_FLUSH, 8'($urandom));
      send(ACT_PIXEL, rand_pixel());
    end
    for (int i = 0; i < 2 * ew + 2; i++) begin
      // A pixel after the frame is complete acts as a flush.
      if ($urandom_range(3) == 0) send(ACT_PIXEL, 8'($urandom));
      else send(ACT_FLUSH, 8'($urandom));
    end
  endtask

  initial begin
    int w, h;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: a few pixels only, nothing comes out this early.
    next_mode();
    for (int i = 0; i < 5; i++) send(ACT_PIXEL, rand_pixel());

    // Zero width and height act as a 1x1 frame; flush before it completes.
    configure(16'd0, 16'd0);
    send(ACT_FLUSH, 8'hFF);
    send(ACT_PIXEL, 8'hFF);
    send(ACT_PIXEL, 8'h00);
    send(ACT_FLUSH, 8'h00);

    // Smallest interior: 5x5 with extreme pixels.
    configure(16'd5, 16'd5);
    for (int i = 0; i < 25; i++) send(ACT_PIXEL, (i % 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 12; i++) send(ACT_FLUSH, 8'h00);

    // Oversized width clamps; tallest height. Partial frames only.
    configure(16'hFFFF, 16'd2);
    for (int i = 0; i < 10; i++) send(ACT_PIXEL, rand_pixel());
    configure(16'd3, 16'hFFFF);
    for (int i = 0; i < 10; i++) send(ACT_PIXEL, rand_pixel());

    // Small frames that pass everything through.
    configure(16'd4, 16'd6);
    run_frame(4, 6, 0);

    // Random frames, most small, under rotating idling patterns.
    while (sent < 540) begin
      next_mode();
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(11, 40);
        h = $urandom_range(5, 7);
      end else begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 9);
      end
      configure(16'(w), 16'(h));
      repeat ($urandom_range(1, 2)) run_frame(w, h, 5);
    end

    drain();
    $display("run: %0d input transactions, %0d results, %0d frames over %0d phases",
             items_seen, results_seen, frames_seen, phase_no);
    $display("geometry from 1x1 to clamped width and full height; four idling patterns");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
